>>> rtl/core/bus_register_block_with_ports_assert.svh
// Assertion macros for the bus register block.
// Each macro checks one implication on the rising clock edge, outside reset.
`ifndef BUS_REGISTER_BLOCK_WITH_PORTS_ASSERT_SVH
`define BUS_REGISTER_BLOCK_WITH_PORTS_ASSERT_SVH

`ifndef ASSERT_OFF
`define BRB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("brb: same-cycle check failed");
`define BRB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("brb: next-cycle check failed");
`else
`define BRB_ASSERT_NOW(lbl, ante, cons)
`define BRB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/brb_pkg.sv
package brb_pkg;

   localparam int STACK_DEPTH_DEF = 512;

   localparam int          EXT_AW    = 16;
   localparam int          EXT_DEPTH = 1 << EXT_AW;
   localparam logic [15:0] EXT_LAST  = 16'hFFFF;

   localparam int CSR_AW = 4;

   localparam logic [1:0] CFG_WIN_LO = 2'd0;
   localparam logic [1:0] CFG_WIN_HI = 2'd1;
   localparam logic [1:0] CFG_AUDIO  = 2'd2;

   localparam logic [15:0] WIN_LO_RST = 16'hFFE0;
   localparam logic [15:0] WIN_HI_RST = 16'hFFFF;
   localparam logic [15:0] AUDIO_RST  = 16'hFFFF;
   localparam logic [15:0] PAGE_MASK  = 16'hFF00;

   localparam logic [2:0] MODE_BUS    = 3'd0;
   localparam logic [2:0] MODE_VSYNC  = 3'd1;
   localparam logic [2:0] MODE_SIGINT = 3'd2;
   localparam logic [2:0] MODE_POLL   = 3'd3;
   localparam logic [2:0] MODE_BREAK  = 3'd4;

   localparam logic [4:0] REG_STATUS = 5'h00;
   localparam logic [4:0] REG_TX     = 5'h01;
   localparam logic [4:0] REG_RX     = 5'h02;
   localparam logic [4:0] REG_PORT0  = 5'h04;
   localparam logic [4:0] REG_STEP0  = 5'h05;
   localparam logic [4:0] REG_PTR0_L = 5'h06;
   localparam logic [4:0] REG_PTR0_H = 5'h07;
   localparam logic [4:0] REG_PORT1  = 5'h08;
   localparam logic [4:0] REG_STEP1  = 5'h09;
   localparam logic [4:0] REG_PTR1_L = 5'h0A;
   localparam logic [4:0] REG_PTR1_H = 5'h0B;
   localparam logic [4:0] REG_STACK  = 5'h0C;
   localparam logic [4:0] REG_OP     = 5'h0F;
   localparam logic [4:0] REG_IRQ    = 5'h10;

   localparam logic [7:0] ST_TX          = 8'h80;
   localparam logic [7:0] ST_RX          = 8'h40;
   localparam logic [7:0] IRQ_VSYNC      = 8'h80;
   localparam logic [7:0] IRQ_SIGINT     = 8'h40;
   localparam logic [7:0] OP_STACK_RESET = 8'h00;
   localparam logic [7:0] POLL_TAKEN     = 8'h01;

   // where the read byte of a result comes from
   localparam logic [1:0] SRC_IMM   = 2'd0;
   localparam logic [1:0] SRC_EXT   = 2'd1;
   localparam logic [1:0] SRC_STACK = 2'd2;

   typedef struct packed {
      logic        we;
      logic        re;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } ext_req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [1:0]  src;
      logic        irq_line;
      logic        chip_selected;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        rx_taken;
      logic        op_valid;
      logic [7:0]  op_code;
      logic        audio_valid;
      logic [15:0] audio_addr;
      logic [7:0]  audio_data;
   } rsp_meta_type;

   typedef struct packed {
      logic s1_valid;
      logic blocked;
   } resp_stat_type;

endpackage

>>> rtl/core/brb_ram.sv
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/brb_ctrl.sv
module brb_ctrl #(
   parameter int STACK_DEPTH = brb_pkg::STACK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [2:0]                     req_mode,
   input  logic [15:0]                    req_address,
   input  logic                           req_is_read,
   input  logic [7:0]                     req_write_data,
   input  logic                           req_rx_available,
   input  logic [7:0]                     req_rx_byte,
   input  logic [15:0]                    win_lo,
   input  logic [15:0]                    win_hi,
   input  logic [15:0]                    audio_page,
   output brb_pkg::ext_req_type           ext_req,
   output logic                           stk_we,
   output logic [$clog2(STACK_DEPTH)-1:0] stk_waddr,
   output logic [7:0]                     stk_wdata,
   output logic                           stk_re,
   output logic [$clog2(STACK_DEPTH)-1:0] stk_raddr,
   output brb_pkg::rsp_meta_type          meta
);

   import brb_pkg::*;

   localparam int               SP_W     = $clog2(STACK_DEPTH + 1);
   localparam int               AW       = $clog2(STACK_DEPTH);
   localparam logic [SP_W-1:0]  SP_EMPTY = SP_W'(STACK_DEPTH);

   logic [7:0]      regs_ff [32];
   logic [7:0]      regs_in [32];
   logic [7:0]      en_ff, en_in;
   logic [7:0]      pend_ff, pend_in;
   logic [SP_W-1:0] sp_ff, sp_in;

   logic            sel;
   logic [4:0]      r;
   logic [7:0]      st;
   logic [7:0]      stp;
   logic [15:0]     ptr;
   logic [15:0]     ptr_next;
   logic            audio_hit;
   logic [SP_W-1:0] sp_dec;

   always_comb begin
      regs_in = regs_ff;
      en_in   = en_ff;
      pend_in = pend_ff;
      sp_in   = sp_ff;

      r   = req_address[4:0];
      sel = req_address inside {[win_lo:win_hi]};
      st  = regs_ff[REG_STATUS];

      // pick port 1 when the register number is REG_PORT1, else port 0
      if (r == REG_PORT1) begin
         ptr = {regs_ff[REG_PTR1_H], regs_ff[REG_PTR1_L]};
         stp = regs_ff[REG_STEP1];
      end else begin
         ptr = {regs_ff[REG_PTR0_H], regs_ff[REG_PTR0_L]};
         stp = regs_ff[REG_STEP0];
      end
      ptr_next  = ptr + {{8{stp[7]}}, stp};
      audio_hit = (ptr & PAGE_MASK) == audio_page;
      sp_dec    = sp_ff - SP_W'(1);

      meta          = '0;
      meta.src      = SRC_IMM;
      meta.irq_line = |(pend_ff & en_ff);

      ext_req       = '0;
      ext_req.addr  = ptr;
      ext_req.wdata = req_write_data;
      stk_we        = 1'b0;
      stk_re        = 1'b0;
      stk_waddr     = sp_dec[AW-1:0];
      stk_raddr     = sp_ff[AW-1:0];
      stk_wdata     = req_write_data;

      case (req_mode)
         MODE_BUS: begin
            if (sel) begin
               meta.chip_selected = 1'b1;
               if (req_is_read) begin
                  case (r)
                     REG_STATUS: begin
                        if (((st & ST_RX) == 8'h00) && req_rx_available) begin
                           regs_in[REG_RX] = req_rx_byte;
                           st              = st | ST_RX;
                           meta.rx_taken   = 1'b1;
                        end
                        st                  = st | ST_TX;
                        regs_in[REG_STATUS] = st;
                        meta.read_data      = st;
                     end
                     REG_RX: begin
                        meta.read_data  = regs_ff[REG_RX];
                        st              = st & ~ST_RX;
                        regs_in[REG_RX] = 8'h00;
                        if (req_rx_available) begin
                           regs_in[REG_RX] = req_rx_byte;
                           st              = st | ST_RX;
                           meta.rx_taken   = 1'b1;
                        end
                        regs_in[REG_STATUS] = st;
                     end
                     REG_PORT0, REG_PORT1: begin
                        ext_req.re = 1'b1;
                        meta.src   = SRC_EXT;
                     end
                     REG_STACK: begin
                        // pop; an empty stack returns zero and stays empty
                        if (sp_ff < SP_EMPTY) begin
                           stk_re   = 1'b1;
                           meta.src = SRC_STACK;
                           sp_in    = sp_ff + SP_W'(1);
                        end
                     end
                     REG_IRQ: begin
                        meta.read_data = pend_ff;
                        pend_in        = 8'h00;
                     end
                     default: begin
                        meta.read_data = regs_ff[r];
                     end
                  endcase
               end else begin
                  case (r)
                     REG_TX: begin
                        meta.tx_valid       = 1'b1;
                        meta.tx_byte        = req_write_data;
                        regs_in[REG_STATUS] = st | ST_TX;
                     end
                     REG_PORT0, REG_PORT1: begin
                        ext_req.we = 1'b1;
                        if (audio_hit) begin
                           meta.audio_valid = 1'b1;
                           meta.audio_addr  = ptr;
                           meta.audio_data  = req_write_data;
                        end
                     end
                     REG_STACK: begin
                        // push; a full stack drops the byte
                        if (sp_ff != '0) begin
                           stk_we = 1'b1;
                           sp_in  = sp_dec;
                        end
                     end
                     REG_OP: begin
                        regs_in[REG_OP] = req_write_data;
                        meta.op_valid   = 1'b1;
                        meta.op_code    = req_write_data;
                        if (req_write_data == OP_STACK_RESET) begin
                           sp_in = SP_EMPTY;
                        end
                     end
                     REG_IRQ: begin
                        en_in   = req_write_data;
                        pend_in = pend_ff & ~req_write_data;
                     end
                     default: begin
                        regs_in[r] = req_write_data;
                     end
                  endcase
               end
               // step the port pointer after every port access
               if (r inside {REG_PORT0, REG_PORT1}) begin
                  if (r == REG_PORT1) begin
                     regs_in[REG_PTR1_L] = ptr_next[7:0];
                     regs_in[REG_PTR1_H] = ptr_next[15:8];
                  end else begin
                     regs_in[REG_PTR0_L] = ptr_next[7:0];
                     regs_in[REG_PTR0_H] = ptr_next[15:8];
                  end
               end
            end
         end
         MODE_VSYNC: begin
            pend_in = pend_ff | IRQ_VSYNC;
         end
         MODE_SIGINT: begin
            pend_in = pend_ff | IRQ_SIGINT;
         end
         MODE_POLL: begin
            if ((pend_ff & IRQ_SIGINT) != 8'h00) begin
               pend_in        = pend_ff & ~IRQ_SIGINT;
               meta.read_data = POLL_TAKEN;
            end
         end
         MODE_BREAK: begin
            regs_in[REG_STATUS] = st & ~ST_RX;
            regs_in[REG_RX]     = 8'h00;
         end
         default: begin
         end
      endcase

      ext_req.we = ext_req.we & accept;
      ext_req.re = ext_req.re & accept;
      stk_we     = stk_we & accept;
      stk_re     = stk_re & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '{default: '0};
         en_ff   <= '0;
         pend_ff <= '0;
         sp_ff   <= SP_EMPTY;
      end else if (accept) begin
         regs_ff <= regs_in;
         en_ff   <= en_in;
         pend_ff <= pend_in;
         sp_ff   <= sp_in;
      end
   end

endmodule

>>> rtl/core/brb_resp.sv
module brb_resp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  brb_pkg::rsp_meta_type  meta_in,
   input  logic [7:0]             ext_rdata,
   input  logic [7:0]             stk_rdata,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output brb_pkg::rsp_meta_type  rsp_meta,
   output brb_pkg::resp_stat_type stat
);

   import brb_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   rsp_meta_type s1_meta_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_meta_type out_meta_ff, out_meta_in;
   logic         out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_meta_in = s1_meta_ff;
      case (s1_meta_ff.src)
         SRC_EXT:   out_meta_in.read_data = ext_rdata;
         SRC_STACK: out_meta_in.read_data = stk_rdata;
         default:   out_meta_in.read_data = s1_meta_ff.read_data;
      endcase

      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta_in;
      end
      if (out_free && s1_valid_ff) begin
         out_meta_ff <= out_meta_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_meta      = out_meta_ff;
   assign stat.s1_valid = s1_valid_ff;
   assign stat.blocked  = s1_valid_ff && !out_free;

endmodule

>>> rtl/core/bus_register_block_with_ports.sv
// Bus register block with two auto-stepping memory ports, a byte stack and
// an interrupt latch.
// Input channel (req_*): one transfer per bus cycle or side event (vsync,
// sigint, sigint poll, break). Result channel (rsp_*): exactly one transfer
// per input transfer, in order. Both channels use valid/stall.
// Path: an input transfer updates the state and reads the memories at its
// accepting edge into the read stage; the output register then passes the
// result to rsp_valid. Throughput: one transfer per cycle while neither the
// sweep nor a stalled result holds req_stall high; every item does at most
// one access to the 64 KiB memory and one to the stack memory, each on its
// own write port and registered read port. Reset: window registers return
// to 0xFFE0..0xFFFF, the audio watch parks, all registers, interrupt state
// and the stack empty. The 64 KiB memory is then swept to zero one byte per cycle, with req_stall high.
// Configuration writes on the APB port are taken during the sweep.
// Stall: a stalled result holds in the output register while one more item
// is taken into the stage behind it; after that req_stall rises.
`include "bus_register_block_with_ports_assert.svh"

module bus_register_block_with_ports #(
   parameter int STACK_DEPTH = brb_pkg::STACK_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_mode,
   input  logic [15:0]               req_address,
   input  logic                      req_is_read,
   input  logic [7:0]                req_write_data,
   input  logic                      req_rx_available,
   input  logic [7:0]                req_rx_byte,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_read_data,
   output logic                      rsp_irq_line,
   output logic                      rsp_chip_selected,
   output logic                      rsp_tx_valid,
   output logic [7:0]                rsp_tx_byte,
   output logic                      rsp_rx_taken,
   output logic                      rsp_op_valid,
   output logic [7:0]                rsp_op_code,
   output logic                      rsp_audio_valid,
   output logic [15:0]               rsp_audio_addr,
   output logic [7:0]                rsp_audio_data,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [brb_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   import brb_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);

   // configuration registers
   logic [15:0] win_lo_ff;
   logic [15:0] win_hi_ff;
   logic [15:0] audio_ff;
   logic        cfg_we;

   // memory clear sweep after reset
   logic              clr_busy_ff;
   logic [EXT_AW-1:0] clr_addr_ff;

   logic          req_accept;
   ext_req_type   ext_req;
   logic          ext_we;
   logic [15:0]   ext_waddr;
   logic [7:0]    ext_wdata;
   logic [7:0]    ext_rdata;
   logic          stk_we;
   logic [AW-1:0] stk_waddr;
   logic [7:0]    stk_wdata;
   logic          stk_re;
   logic [AW-1:0] stk_raddr;
   logic [7:0]    stk_rdata;

   rsp_meta_type  meta;
   rsp_meta_type  rsp_meta;
   resp_stat_type resp_stat;

   //------------------------------------------------------------------
   // APB configuration port: zero wait states, 16-bit registers at 4*i
   //------------------------------------------------------------------
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_lo_ff <= WIN_LO_RST;
         win_hi_ff <= WIN_HI_RST;
         audio_ff  <= AUDIO_RST;
      end else if (cfg_we) begin
         case (paddr[3:2])
            CFG_WIN_LO: win_lo_ff <= pwdata[15:0];
            CFG_WIN_HI: win_hi_ff <= pwdata[15:0];
            CFG_AUDIO:  audio_ff  <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CFG_WIN_LO: prdata = {16'h0000, win_lo_ff};
         CFG_WIN_HI: prdata = {16'h0000, win_hi_ff};
         CFG_AUDIO:  prdata = {16'h0000, audio_ff};
         default:    prdata = 32'h0000_0000;
      endcase
   end

   //------------------------------------------------------------------
   // Clear sweep: write zero to every memory byte, then open the input
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + EXT_AW'(1);
         if (clr_addr_ff == EXT_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // hold off input during the sweep and while a stalled result fills both stages
   assign req_stall  = clr_busy_ff || resp_stat.blocked;
   assign req_accept = req_valid && !req_stall;

   //------------------------------------------------------------------
   // Register decode, stack pointer and interrupt latch
   //------------------------------------------------------------------
   brb_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .req_mode         (req_mode),
      .req_address      (req_address),
      .req_is_read      (req_is_read),
      .req_write_data   (req_write_data),
      .req_rx_available (req_rx_available),
      .req_rx_byte      (req_rx_byte),
      .win_lo           (win_lo_ff),
      .win_hi           (win_hi_ff),
      .audio_page       (audio_ff),
      .ext_req          (ext_req),
      .stk_we           (stk_we),
      .stk_waddr        (stk_waddr),
      .stk_wdata        (stk_wdata),
      .stk_re           (stk_re),
      .stk_raddr        (stk_raddr),
      .meta             (meta)
   );

   //------------------------------------------------------------------
   // Memories: the sweep owns the write port until it ends
   //------------------------------------------------------------------
   assign ext_we    = clr_busy_ff || ext_req.we;
   assign ext_waddr = clr_busy_ff ? clr_addr_ff : ext_req.addr;
   assign ext_wdata = clr_busy_ff ? 8'h00 : ext_req.wdata;

   brb_ram #(
      .WIDTH (8),
      .DEPTH (EXT_DEPTH)
   ) u_ext_ram (
      .clock (clock),
      .we    (ext_we),
      .waddr (ext_waddr),
      .wdata (ext_wdata),
      .re    (ext_req.re),
      .raddr (ext_req.addr),
      .rdata (ext_rdata)
   );

   // entries at or above the stack pointer are always written before use
   brb_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   //------------------------------------------------------------------
   // Result pipeline: memory read stage, then output register
   //------------------------------------------------------------------
   brb_resp u_resp (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .meta_in   (meta),
      .ext_rdata (ext_rdata),
      .stk_rdata (stk_rdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_meta  (rsp_meta),
      .stat      (resp_stat)
   );

   assign rsp_read_data     = rsp_meta.read_data;
   assign rsp_irq_line      = rsp_meta.irq_line;
   assign rsp_chip_selected = rsp_meta.chip_selected;
   assign rsp_tx_valid      = rsp_meta.tx_valid;
   assign rsp_tx_byte       = rsp_meta.tx_byte;
   assign rsp_rx_taken      = rsp_meta.rx_taken;
   assign rsp_op_valid      = rsp_meta.op_valid;
   assign rsp_op_code       = rsp_meta.op_code;
   assign rsp_audio_valid   = rsp_meta.audio_valid;
   assign rsp_audio_addr    = rsp_meta.audio_addr;
   assign rsp_audio_data    = rsp_meta.audio_data;

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   `BRB_ASSERT_NOW(a_ext_single_access, ext_req.re, !ext_req.we)
   `BRB_ASSERT_NEXT(a_sweep_not_restarted, !clr_busy_ff, !clr_busy_ff)
   `BRB_ASSERT_NEXT(a_accept_fills_stage, req_accept, resp_stat.s1_valid)
   `BRB_ASSERT_NOW(a_sweep_pipeline_empty, clr_busy_ff, !resp_stat.s1_valid && !rsp_valid)

endmodule

>>> tb/tb_bus_register_block_with_ports.sv
`timescale 1ns / 100ps

module tb_bus_register_block_with_ports;
   import brb_pkg::*;

   localparam int          STACK_DEPTH = STACK_DEPTH_DEF;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          HOLD_CYCLES = 300;
   localparam bit          ACC_READ    = 1'b1;
   localparam bit          ACC_WRITE   = 1'b0;
   localparam logic [2:0]  MODE_UNUSED = 3'd7;

   // one bus cycle or side event, in port order
   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] address;
      logic        is_read;
      logic [7:0]  write_data;
      logic        rx_available;
      logic [7:0]  rx_byte;
   } bus_cycle_type;

   // one result transfer, in port order
   typedef struct packed {
      logic [7:0]  read_data;
      logic        irq_line;
      logic        chip_selected;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        rx_taken;
      logic        op_valid;
      logic [7:0]  op_code;
      logic        audio_valid;
      logic [15:0] audio_addr;
      logic [7:0]  audio_data;
   } bus_reply_type;

   // Scoreboard: tracks the register block state and queues the reply that
   // each accepted transfer must produce.
   class bus_reply_scoreboard;
      logic [15:0]   win_lo   = WIN_LO_RST;
      logic [15:0]   win_hi   = WIN_HI_RST;
      logic [15:0]   audio_pg = AUDIO_RST;
      bit [7:0]      regs [32];
      bit [7:0]      irq_en;
      bit [7:0]      irq_pend;
      bit [7:0]      stack_mem [STACK_DEPTH + 1];
      int unsigned   sp = STACK_DEPTH;
      bit [7:0]      ext_mem [EXT_DEPTH];
      bus_reply_type rep;
      bus_reply_type expected_replies[$];
      int unsigned   noted;
      int unsigned   checked;
      int unsigned   failures;

      function void configure(input logic [1:0] idx, input logic [15:0] value);
         case (idx)
            CFG_WIN_LO: win_lo = value;
            CFG_WIN_HI: win_hi = value;
            CFG_AUDIO:  audio_pg = value;
            default: ;
         endcase
      endfunction

      function void latch_rx(input bus_cycle_type c);
         if (c.rx_available) begin
            regs[REG_RX] = c.rx_byte;
            regs[REG_STATUS] |= ST_RX;
            rep.rx_taken = 1'b1;
         end
      endfunction

      function bit [7:0] stack_at(input int unsigned p);
         return (p <= STACK_DEPTH) ? stack_mem[p] : 8'h00;
      endfunction

      // access the memory through one port, then advance its pointer
      function bit [7:0] port_access(input logic [4:0] port, input bit rd,
                                     input logic [7:0] d);
         int          b;
         logic [15:0] a;
         bit [7:0]    v;
         b = port;
         a = {regs[b + 3], regs[b + 2]};
         v = 8'h00;
         if (rd) begin
            v = ext_mem[a];
         end else begin
            ext_mem[a] = d;
            if ((a & PAGE_MASK) == audio_pg) begin
               rep.audio_valid = 1'b1;
               rep.audio_addr  = a;
               rep.audio_data  = d;
            end
         end
         a = a + {{8{regs[b + 1][7]}}, regs[b + 1]};
         regs[b + 2] = a[7:0];
         regs[b + 3] = a[15:8];
         return v;
      endfunction

      function bus_reply_type predict_reply(input bus_cycle_type c);
         logic [4:0] r;
         logic [7:0] d;
         r = c.address[4:0];
         d = c.write_data;
         rep = '0;
         rep.irq_line = (irq_pend & irq_en) != 8'h00;
         case (c.mode)
            MODE_BUS: if (c.address inside {[win_lo:win_hi]}) begin
               rep.chip_selected = 1'b1;
               if (c.is_read) begin
                  case (r)
                     REG_STATUS: begin
                        if (!(regs[REG_STATUS] & ST_RX)) latch_rx(c);
                        regs[REG_STATUS] |= ST_TX;
                        rep.read_data = regs[REG_STATUS];
                     end
                     REG_RX: begin
                        rep.read_data = regs[REG_RX];
                        regs[REG_RX] = 8'h00;
                        regs[REG_STATUS] &= ~ST_RX;
                        latch_rx(c);
                     end
                     REG_PORT0, REG_PORT1: rep.read_data = port_access(r, 1'b1, 8'h00);
                     REG_STACK: begin
                        rep.read_data = stack_at(sp);
                        if (sp < STACK_DEPTH) sp++;
                     end
                     REG_IRQ: begin
                        rep.read_data = irq_pend;
                        irq_pend = 8'h00;
                     end
                     default: rep.read_data = regs[r];
                  endcase
               end else begin
                  case (r)
                     REG_TX: begin
                        rep.tx_valid = 1'b1;
                        rep.tx_byte  = d;
                        regs[REG_STATUS] |= ST_TX;
                     end
                     REG_PORT0, REG_PORT1: void'(port_access(r, 1'b0, d));
                     REG_STACK: if (sp inside {[1:STACK_DEPTH]}) begin
                        sp--;
                        stack_mem[sp] = d;
                     end
                     REG_OP: begin
                        regs[REG_OP] = d;
                        rep.op_valid = 1'b1;
                        rep.op_code  = d;
                        if (d == OP_STACK_RESET) sp = STACK_DEPTH;
                     end
                     REG_IRQ: begin
                        irq_en = d;
                        irq_pend &= ~d;
                     end
                     default: regs[r] = d;
                  endcase
               end
            end
            MODE_VSYNC:  irq_pend |= IRQ_VSYNC;
            MODE_SIGINT: irq_pend |= IRQ_SIGINT;
            MODE_POLL: if (irq_pend & IRQ_SIGINT) begin
               irq_pend &= ~IRQ_SIGINT;
               rep.read_data = POLL_TAKEN;
            end
            MODE_BREAK: begin
               regs[REG_STATUS] &= ~ST_RX;
               regs[REG_RX] = 8'h00;
            end
            default: ;
         endcase
         return rep;
      endfunction

      function void note_cycle(input bus_cycle_type c);
         expected_replies.push_back(predict_reply(c));
         noted++;
      endfunction

      function string reply_text(input bus_reply_type r);
         return {$sformatf("rd=%02h irq=%0b cs=%0b tx=%0b/%02h rx_taken=%0b ",
                           r.read_data, r.irq_line, r.chip_selected, r.tx_valid,
                           r.tx_byte, r.rx_taken),
                 $sformatf("op=%0b/%02h audio=%0b/%04h/%02h",
                           r.op_valid, r.op_code, r.audio_valid, r.audio_addr,
                           r.audio_data)};
      endfunction

      function void check_reply(input bus_reply_type got);
         bus_reply_type want;
         checked++;
         if (expected_replies.size() == 0) begin
            failures++;
            if (failures <= 10) $display("ERROR: result with nothing outstanding: %s",
                                         reply_text(got));
            return;
         end
         want = expected_replies.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10) begin
               $display("ERROR: result %0d mismatch", checked);
               $display("  expected %s", reply_text(want));
               $display("  actual   %s", reply_text(got));
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_mode;
   logic [15:0] req_address;
   logic        req_is_read;
   logic [7:0]  req_write_data;
   logic        req_rx_available;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_read_data;
   logic        rsp_irq_line;
   logic        rsp_chip_selected;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_rx_taken;
   logic        rsp_op_valid;
   logic [7:0]  rsp_op_code;
   logic        rsp_audio_valid;
   logic [15:0] rsp_audio_addr;
   logic [7:0]  rsp_audio_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bus_reply_scoreboard sb;
   int unsigned items_sent;
   int unsigned cycle_count;
   bit          calm;           // final stretch: no idling on either side
   bit          long_hold_req;  // ask the receiver for one long hold-off

   bus_register_block_with_ports #(.STACK_DEPTH(STACK_DEPTH)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_address       (req_address),
      .req_is_read       (req_is_read),
      .req_write_data    (req_write_data),
      .req_rx_available  (req_rx_available),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_irq_line      (rsp_irq_line),
      .rsp_chip_selected (rsp_chip_selected),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_rx_taken      (rsp_rx_taken),
      .rsp_op_valid      (rsp_op_valid),
      .rsp_op_code       (rsp_op_code),
      .rsp_audio_valid   (rsp_audio_valid),
      .rsp_audio_addr    (rsp_audio_addr),
      .rsp_audio_data    (rsp_audio_data),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Count cycles; end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
   end

   // Sample both channels at the rising edge: check the result transfer
   // first, then predict from the input transfer (latency keeps them apart).
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_reply({rsp_read_data, rsp_irq_line, rsp_chip_selected, rsp_tx_valid,
                            rsp_tx_byte, rsp_rx_taken, rsp_op_valid, rsp_op_code,
                            rsp_audio_valid, rsp_audio_addr, rsp_audio_data});
         end
         if (req_valid && !req_stall) begin
            sb.note_cycle({req_mode, req_address, req_is_read, req_write_data,
                           req_rx_available, req_rx_byte});
         end
      end
   end

   // Receiver: stall in random bursts, with quiet stretches between; serve
   // one long hold-off on request so the block backs up into req_stall.
   initial begin : rsp_side
      int unsigned n;
      bit          hold;
      rsp_stall = 1'b0;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            n = HOLD_CYCLES;
            hold = 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 12);
            hold = 1'b1;
         end else begin
            n = $urandom_range(1, 30);
            hold = 1'b0;
         end
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= hold;
         end
      end
   end

   // Pick an address that selects register r in the current window; fall back to
   // any in-window address when the alignment does not fit; any address when reversed.
   function automatic logic [15:0] reg_addr(input logic [4:0] r);
      logic [15:0] a;
      if (sb.win_lo > sb.win_hi) return 16'($urandom);
      a = 16'($urandom_range(sb.win_hi, sb.win_lo));
      a[4:0] = r;
      if (a < sb.win_lo || a > sb.win_hi) a = 16'($urandom_range(sb.win_hi, sb.win_lo));
      return a;
   endfunction

   function automatic bus_cycle_type noise_cycle();
      bus_cycle_type c;
      c.mode         = 3'($urandom_range(0, 7));
      c.address      = $urandom_range(0, 1) ? reg_addr(5'($urandom)) : 16'($urandom);
      c.is_read      = 1'($urandom);
      c.write_data   = 8'($urandom);
      c.rx_available = 1'($urandom);
      c.rx_byte      = 8'($urandom);
      return c;
   endfunction

   function automatic bus_cycle_type bus_op(input bit rd, input logic [4:0] r,
                                            input logic [7:0] d);
      bus_cycle_type c;
      c            = noise_cycle();
      c.mode       = MODE_BUS;
      c.address    = reg_addr(r);
      c.is_read    = rd;
      c.write_data = d;
      return c;
   endfunction

   function automatic bus_cycle_type side_event(input logic [2:0] m);
      bus_cycle_type c;
      c      = noise_cycle();
      c.mode = m;
      return c;
   endfunction

   // Offer one transfer: maybe idle first, then hold the payload until taken.
   task automatic offer(input bus_cycle_type c);
      if (!calm && $urandom_range(0, 11) == 0) begin
         repeat ($urandom_range(1, 12)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      {req_mode, req_address, req_is_read, req_write_data, req_rx_available,
       req_rx_byte} <= c;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Drop valid and wait until every outstanding result has arrived.
   task automatic drain_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'h0000, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.configure(idx, value);
   endtask

   // Program a step and pointer, write a run of bytes, rewind, read them back.
   task automatic port_burst();
      logic [4:0]  port;
      logic [4:0]  step_reg;
      logic [4:0]  lo_reg;
      logic [4:0]  hi_reg;
      logic [7:0]  step;
      logic [15:0] ptr;
      int unsigned n;
      if ($urandom_range(0, 1)) begin
         port = REG_PORT1; step_reg = REG_STEP1; lo_reg = REG_PTR1_L; hi_reg = REG_PTR1_H;
      end else begin
         port = REG_PORT0; step_reg = REG_STEP0; lo_reg = REG_PTR0_L; hi_reg = REG_PTR0_H;
      end
      step = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8) - 4);
      ptr  = 16'($urandom);
      if ($urandom_range(0, 1)) ptr[15:8] = sb.audio_pg[15:8];
      n = $urandom_range(1, 12);
      offer(bus_op(ACC_WRITE, step_reg, step));
      offer(bus_op(ACC_WRITE, lo_reg, ptr[7:0]));
      offer(bus_op(ACC_WRITE, hi_reg, ptr[15:8]));
      repeat (n) offer(bus_op(ACC_WRITE, port, 8'($urandom)));
      offer(bus_op(ACC_WRITE, lo_reg, ptr[7:0]));
      offer(bus_op(ACC_WRITE, hi_reg, ptr[15:8]));
      repeat (n) offer(bus_op(ACC_READ, port, 8'h00));
      if ($urandom_range(0, 1)) begin
         offer(bus_op(ACC_READ, lo_reg, 8'h00));
         offer(bus_op(ACC_READ, hi_reg, 8'h00));
         offer(bus_op(ACC_READ, step_reg, 8'h00));
      end
   endtask

   // Push a few bytes, sometimes empty the stack by operation, pop as many or up to three more.
   task automatic stack_burst();
      int unsigned k;
      k = $urandom_range(1, 10);
      repeat (k) offer(bus_op(ACC_WRITE, REG_STACK, 8'($urandom)));
      if ($urandom_range(0, 4) == 0) offer(bus_op(ACC_WRITE, REG_OP, OP_STACK_RESET));
      repeat (k + $urandom_range(0, 3)) offer(bus_op(ACC_READ, REG_STACK, 8'h00));
   endtask

   // Fill the stack beyond full, pop, empty it by operation, pop empty.
   task automatic stack_fill();
      repeat (STACK_DEPTH + 2) offer(bus_op(ACC_WRITE, REG_STACK, 8'($urandom)));
      repeat (3) offer(bus_op(ACC_READ, REG_STACK, 8'h00));
      offer(bus_op(ACC_WRITE, REG_OP, OP_STACK_RESET));
      repeat (2) offer(bus_op(ACC_READ, REG_STACK, 8'h00));
   endtask

   task automatic uart_burst();
      repeat ($urandom_range(3, 8)) begin
         case ($urandom_range(0, 5))
            0: offer(bus_op(ACC_READ, REG_STATUS, 8'h00));
            1: offer(bus_op(ACC_READ, REG_RX, 8'h00));
            2: offer(bus_op(ACC_WRITE, REG_TX, 8'($urandom)));
            3: offer(side_event(MODE_BREAK));
            4: offer(bus_op(ACC_WRITE, $urandom_range(0, 1) ? REG_STATUS : REG_RX,
                            8'($urandom)));
            default: offer(bus_op(1'($urandom), 5'($urandom), 8'($urandom)));
         endcase
      end
   endtask

   task automatic irq_burst();
      logic [7:0] mask;
      repeat ($urandom_range(3, 8)) begin
         case ($urandom_range(0, 5))
            0: begin
               case ($urandom_range(0, 4))
                  0: mask = IRQ_VSYNC;
                  1: mask = IRQ_SIGINT;
                  2: mask = IRQ_VSYNC | IRQ_SIGINT;
                  3: mask = 8'h00;
                  default: mask = 8'($urandom);
               endcase
               offer(bus_op(ACC_WRITE, REG_IRQ, mask));
            end
            1: offer(side_event(MODE_VSYNC));
            2: offer(side_event(MODE_SIGINT));
            3: offer(side_event(MODE_POLL));
            4: offer(bus_op(ACC_READ, REG_IRQ, 8'h00));
            default: offer(bus_op(ACC_WRITE, REG_OP, 8'($urandom)));
         endcase
      end
   endtask

   task automatic random_phase(input int unsigned target);
      int unsigned stop;
      stop = items_sent + target;
      while (items_sent < stop) begin
         case ($urandom_range(0, 9))
            0, 1, 2: port_burst();
            3:       stack_burst();
            4, 5:    uart_burst();
            6, 7:    irq_burst();
            default: offer(noise_cycle());
         endcase
      end
   endtask

   // Directed opening under the default window 0xFFE0..0xFFFF.
   task automatic directed_items();
      bus_cycle_type c;
      // status read latches an offered byte, then sees rx ready and leaves it
      c = bus_op(ACC_READ, REG_STATUS, 8'h00);
      c.rx_available = 1'b1; c.rx_byte = 8'hFF;
      offer(c);
      c = bus_op(ACC_READ, REG_STATUS, 8'h00);
      c.rx_available = 1'b1; c.rx_byte = 8'h00;
      offer(c);
      // rx read returns the held byte and latches the next one
      c = bus_op(ACC_READ, REG_RX, 8'h00);
      c.rx_available = 1'b1; c.rx_byte = 8'h5A;
      offer(c);
      offer(side_event(MODE_BREAK));
      c = bus_op(ACC_READ, REG_RX, 8'h00);
      c.rx_available = 1'b0;
      offer(c);
      offer(bus_op(ACC_WRITE, REG_TX, 8'hFF));
      // port 0 steps backward through the watched page; port 1 reads it back
      offer(bus_op(ACC_WRITE, REG_STEP0, 8'hFF));
      offer(bus_op(ACC_WRITE, REG_PTR0_L, 8'h00));
      offer(bus_op(ACC_WRITE, REG_PTR0_H, 8'h12));
      offer(bus_op(ACC_WRITE, REG_PORT0, 8'hA5));
      offer(bus_op(ACC_WRITE, REG_PTR1_H, 8'h12));
      offer(bus_op(ACC_READ, REG_PORT1, 8'h00));
      // push, pop, pop from empty
      offer(bus_op(ACC_WRITE, REG_STACK, 8'h77));
      offer(bus_op(ACC_READ, REG_STACK, 8'h00));
      offer(bus_op(ACC_READ, REG_STACK, 8'h00));
      offer(bus_op(ACC_WRITE, REG_OP, 8'hFF));
      offer(bus_op(ACC_WRITE, REG_OP, OP_STACK_RESET));
      // interrupt latch: enable all, raise both, poll twice, read and clear
      offer(bus_op(ACC_WRITE, REG_IRQ, 8'hFF));
      offer(side_event(MODE_VSYNC));
      offer(side_event(MODE_SIGINT));
      offer(side_event(MODE_POLL));
      offer(side_event(MODE_POLL));
      offer(bus_op(ACC_READ, REG_IRQ, 8'h00));
      offer(side_event(MODE_UNUSED));
      // address extremes: below the window, and the top register
      c = bus_op(ACC_WRITE, REG_STATUS, 8'h00);
      c.address = 16'h0000;
      offer(c);
      c = bus_op(ACC_READ, REG_STATUS, 8'h00);
      c.address = 16'hFFFF;
      offer(c);
   endtask

   initial begin
      sb               = new;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_BUS;
      req_address      = 16'h0000;
      req_is_read      = 1'b0;
      req_write_data   = 8'h00;
      req_rx_available = 1'b0;
      req_rx_byte      = 8'h00;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = 32'h0;
      cycle_count      = 0;
      items_sent       = 0;
      calm             = 1'b0;
      long_hold_req    = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default window, watch a mid page; the memory sweep runs meanwhile.
      write_csr(CFG_WIN_LO, 16'hFFE0);
      write_csr(CFG_WIN_HI, 16'hFFFF);
      write_csr(CFG_AUDIO, 16'h1200);
      directed_items();
      long_hold_req = 1'b1;
      random_phase(400);
      drain_replies();

      // Whole address space selects; watch page zero; take the stack to full.
      write_csr(CFG_WIN_LO, 16'h0000);
      write_csr(CFG_AUDIO, 16'h0000);
      stack_fill();
      random_phase(250);
      drain_replies();

      // Reversed window selects nothing; watch parked.
      write_csr(CFG_WIN_LO, 16'hFFFF);
      write_csr(CFG_WIN_HI, 16'h0000);
      write_csr(CFG_AUDIO, AUDIO_RST);
      random_phase(40);
      drain_replies();

      // Unaligned narrow window; watch value that is no page.
      write_csr(CFG_WIN_LO, 16'h1008);
      write_csr(CFG_WIN_HI, 16'h1107);
      write_csr(CFG_AUDIO, 16'h34AB);
      random_phase(250);
      drain_replies();

      // Back to the default window, watch the top page, no idling.
      calm = 1'b1;
      write_csr(CFG_WIN_LO, 16'hFFE0);
      write_csr(CFG_WIN_HI, 16'hFFFF);
      write_csr(CFG_AUDIO, 16'hFF00);
      random_phase(200);
      drain_replies();

      $display("Run covered %0d transfers (%0d predicted) over five window/watch setups,",
               items_sent, sb.noted);
      $display("  full and empty stack, port wrap and watch hits; %0d results, %0d mismatches.",
               sb.checked, sb.failures + sb.expected_replies.size());
      if (sb.failures == 0 && sb.expected_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
